// ===== design/u8sd_pkg.sv =====
// Package for the UTF-8 stream decoder: lead-byte masks, widths and the
// job descriptor passed from the front end to the back end.
// No dependencies.
package u8sd_pkg;

  localparam int unsigned CP_W       = 31;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HELD_DEPTH = 4;
  localparam int unsigned PRE_DEPTH  = HELD_DEPTH + 1;

  // Lead byte patterns (mask, match) for 2..6 byte sequences
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_MATCH = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_MATCH = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_MATCH = 8'hF0;
  localparam logic [7:0] LEAD5_MASK  = 8'hFC;
  localparam logic [7:0] LEAD5_MATCH = 8'hF8;
  localparam logic [7:0] LEAD6_MASK  = 8'hFE;
  localparam logic [7:0] LEAD6_MATCH = 8'hFC;

  localparam logic [7:0] PAY2_MASK = 8'h1F;
  localparam logic [7:0] PAY3_MASK = 8'h0F;
  localparam logic [7:0] PAY4_MASK = 8'h07;
  localparam logic [7:0] PAY5_MASK = 8'h03;
  localparam logic [7:0] PAY6_MASK = 8'h01;
  localparam logic [7:0] CONT_PAY_MASK = 8'h3F;

  // One job = a run of raw prefix bytes (lead then held continuations),
  // optionally followed by one tail result.
  typedef struct packed {
    logic [2:0]                      pre_n;
    logic [PRE_DEPTH-1:0][BYTE_W-1:0] pre_bytes;
    logic                            has_tail;
    logic [CP_W-1:0]                 tail_cp;
    logic                            tail_raw;
  } job_t;

endpackage

// ===== design/u8sd_if.sv =====
// Handshake interfaces for the UTF-8 stream decoder: byte input channel
// and code point result channel. Depends on u8sd_pkg.
interface u8sd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u8sd_pkg::BYTE_W-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8sd_cp_if;
  logic                      valid;
  logic                      ready;
  logic [u8sd_pkg::CP_W-1:0] code_point;
  logic                      raw_fallback;
  logic                      last_of_run;

  modport source (output valid, output code_point, output raw_fallback,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input raw_fallback,
                  input last_of_run, output ready);
endinterface

// ===== design/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder top level: front end, job queue and back end.
// A byte's results pass through the job queue register and then the back end's output register.
// Throughput: one byte per cycle while the job queue has room; a byte causing n results holds
//   the back end until all n are loaded, the job queue (QUEUE_DEPTH jobs) soaks up fallback runs.
// Reset: rst_n synchronous, active low; clears sequence state, queue and output valid.
// Depends on u8sd_pkg, u8sd_if, u8sd_front, u8sd_queue, u8sd_back.
module utf8_stream_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  u8sd_byte_if.sink   in_ch,
  u8sd_cp_if.source   out_ch
);

  // job handoff between the two halves
  u8sd_pkg::job_t push_job;
  u8sd_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_not_empty;

  // Front end: one byte per beat whenever the queue has room. A lead byte gives no job unless
  // it breaks an open sequence; mid-sequence continuations produce no job.
  u8sd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  // Decouples byte intake from result delivery
  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back end: expands each job (raw prefix run, then optional tail) into
  // result beats, flagging the final one of the job.
  u8sd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_not_empty),
    .job       (head_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/u8sd_front.sv =====
// Front end: accepts bytes, tracks the open sequence and turns each byte
// into at most one job. Depends on u8sd_pkg and u8sd_byte_if.
module u8sd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  u8sd_byte_if.sink            in_ch,
  input  logic                 q_full,
  output logic                 push,
  output u8sd_pkg::job_t       job
);

  logic [2:0]                      rem_r, rem_nxt;
  logic [u8sd_pkg::CP_W-1:0]       acc_r, acc_nxt;
  logic [7:0]                      lead_r, lead_nxt;
  logic [2:0]                      cnt_r, cnt_nxt;
  logic [u8sd_pkg::HELD_DEPTH-1:0][7:0] held_r;

  logic                            held_we;
  logic [1:0]                      held_wa;
  logic                            job_ok;
  logic                            fresh_en;
  logic                            take;
  logic [7:0]                      c;
  logic [2:0]                      f_len;
  logic [u8sd_pkg::CP_W-1:0]       f_pay;
  logic [u8sd_pkg::CP_W-1:0]       acc_sh;

  assign c        = in_ch.text_byte;
  assign in_ch.ready = !q_full;
  assign take     = in_ch.valid && !q_full;
  assign push     = take && job_ok;
  assign acc_sh   = {acc_r[u8sd_pkg::CP_W-7:0], c[5:0]};

  // lead byte classification
  always_comb begin
    f_len = 3'd0;
    f_pay = '0;
    if ((c & u8sd_pkg::LEAD2_MASK) == u8sd_pkg::LEAD2_MATCH) begin
      f_len = 3'd1;
      f_pay = {23'b0, c & u8sd_pkg::PAY2_MASK};
    end else if ((c & u8sd_pkg::LEAD3_MASK) == u8sd_pkg::LEAD3_MATCH) begin
      f_len = 3'd2;
      f_pay = {23'b0, c & u8sd_pkg::PAY3_MASK};
    end else if ((c & u8sd_pkg::LEAD4_MASK) == u8sd_pkg::LEAD4_MATCH) begin
      f_len = 3'd3;
      f_pay = {23'b0, c & u8sd_pkg::PAY4_MASK};
    end else if ((c & u8sd_pkg::LEAD5_MASK) == u8sd_pkg::LEAD5_MATCH) begin
      f_len = 3'd4;
      f_pay = {23'b0, c & u8sd_pkg::PAY5_MASK};
    end else if ((c & u8sd_pkg::LEAD6_MASK) == u8sd_pkg::LEAD6_MATCH) begin
      f_len = 3'd5;
      f_pay = {23'b0, c & u8sd_pkg::PAY6_MASK};
    end
  end

  always_comb begin
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    lead_nxt = lead_r;
    cnt_nxt  = cnt_r;
    held_we  = 1'b0;
    held_wa  = cnt_r[1:0];
    job      = '0;
    job_ok   = 1'b0;
    fresh_en = 1'b0;

    if (rem_r != 3'd0) begin
      if (c == 8'h00) begin
        // zero inside a sequence: flush the partial value, swallow the zero
        job.has_tail = 1'b1;
        job.tail_cp  = acc_r;
        job_ok       = 1'b1;
        rem_nxt = '0; acc_nxt = '0; lead_nxt = '0; cnt_nxt = '0;
      end else if (c[7:6] == 2'b10) begin
        acc_nxt = acc_sh;
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          job.has_tail = 1'b1;
          job.tail_cp  = acc_sh;
          job_ok       = 1'b1;
          rem_nxt = '0; acc_nxt = '0; lead_nxt = '0; cnt_nxt = '0;
        end else if (cnt_r < 3'(u8sd_pkg::HELD_DEPTH)) begin
          held_we = 1'b1;
          cnt_nxt = cnt_r + 3'd1;
        end
      end else begin
        // broken sequence: replay lead and held bytes raw, then re-handle c
        job.pre_n        = cnt_r + 3'd1;
        job.pre_bytes[0] = lead_r;
        for (int i = 0; i < u8sd_pkg::HELD_DEPTH; i++) begin
          job.pre_bytes[i+1] = held_r[i];
        end
        job_ok = 1'b1;
        rem_nxt = '0; acc_nxt = '0; lead_nxt = '0; cnt_nxt = '0;
        fresh_en = 1'b1;
      end
    end else begin
      fresh_en = 1'b1;
    end

    if (fresh_en) begin
      if (f_len != 3'd0) begin
        rem_nxt  = f_len;
        acc_nxt  = f_pay;
        lead_nxt = c;
        cnt_nxt  = '0;
      end else begin
        job.has_tail = 1'b1;
        job.tail_cp  = {23'b0, c};
        job.tail_raw = c[7];
        job_ok       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      acc_r  <= '0;
      lead_r <= '0;
      cnt_r  <= '0;
    end else if (take) begin
      rem_r  <= rem_nxt;
      acc_r  <= acc_nxt;
      lead_r <= lead_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_we) begin
      held_r[held_wa] <= c;
    end
  end

endmodule

// ===== design/u8sd_queue.sv =====
// Job queue between front and back end, a small register FIFO.
// Depends on u8sd_pkg.
module u8sd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  u8sd_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output u8sd_pkg::job_t head_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8sd_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/u8sd_back.sv =====
// Back end: walks the head job one result per beat, while the output is not stalled, into the output
// register. Depends on u8sd_pkg and u8sd_cp_if.
module u8sd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  u8sd_pkg::job_t job,
  output logic           pop,
  u8sd_cp_if.source      out_ch
);

  logic [2:0]                idx_r;
  logic [2:0]                total;
  logic                      last;
  logic                      load;
  logic [u8sd_pkg::CP_W-1:0] cp_sel;
  logic                      raw_sel;
  logic                      out_valid_r;
  logic [u8sd_pkg::CP_W-1:0] out_cp_r;
  logic                      out_raw_r;
  logic                      out_last_r;

  assign total = job.pre_n + {2'b0, job.has_tail};
  assign last  = (idx_r == total - 3'd1);
  assign load  = job_valid && (!out_valid_r || out_ch.ready);
  assign pop   = load && last;

  always_comb begin
    if (idx_r < job.pre_n) begin
      cp_sel  = {23'b0, job.pre_bytes[idx_r]};
      raw_sel = 1'b1;
    end else begin
      cp_sel  = job.tail_cp;
      raw_sel = job.tail_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= last ? 3'd0 : idx_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp_r   <= cp_sel;
      out_raw_r  <= raw_sel;
      out_last_r <= last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_point   = out_cp_r;
  assign out_ch.raw_fallback = out_raw_r;
  assign out_ch.last_of_run  = out_last_r;

endmodule
